FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the RTC date converter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/rtcb2e_pkg.sv
// Package for the RTC BCD date to epoch converter: register indexes,
// calendar constants, BCD decode and cumulative month-day lookup. No dependencies.
package rtcb2e_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ZoneW     = 18;

  localparam logic [CfgIdxW-1:0] CFG_BCD_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TWELVE_HOUR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ZONE_OFFSET = 2'd2;

  localparam logic [7:0]  PM_FLAG      = 8'h80;
  localparam logic [7:0]  EPOCH_YEARS  = 8'd30;    // 2000 - 1970
  localparam logic [16:0] DAYS_PER_YR  = 17'd365;
  localparam logic [16:0] SEC_PER_HR   = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;

  // hi*10 + lo, nibbles above 9 pass through (range check comes later)
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    bcd_to_bin = 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0}) + 8'(v[3:0]);
  endfunction

  // days before the first of month mon (1..12)
  function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    cum_days = base + 9'((leap && (mon > 4'd2)) ? 1 : 0);
  endfunction

endpackage

FILE: hw/rtl/rtc_bcd_date_to_epoch.sv
// RTC register snapshot (BCD or binary, 12/24 h) to Unix epoch seconds, 2000-2099.
// Uses rtcb2e_pkg and assert_macros.svh.
// Throughput one item per cycle while m_axis_tready does not stall the output.
// Four register stages: decode/check, day count + time of day, days*86400 multiply, final add.
// Reset (rst_ni low, async): pipeline empties, bcd_mode=1, twelve_hour_mode=0, offset=0.
`include "assert_macros.svh"

module rtc_bcd_date_to_epoch
  import rtcb2e_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ZoneW-1:0]   cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [7:0] seconds_raw, [15:8] minutes_raw, [23:16] hours_raw,
  // [31:24] day_raw, [39:32] month_raw, [47:40] year_raw
  input  logic [47:0]        s_axis_tdata,
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] epoch_seconds
  output logic [31:0]        m_axis_tdata,
  // [0] date_error
  output logic               m_axis_tuser
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic                    bcd_q, twelve_q;
  logic signed [ZoneW-1:0] zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q    <= 1'b1;
      twelve_q <= 1'b0;
      zone_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BCD_MODE:    bcd_q    <= cfg_wdata_i[0];
        CFG_TWELVE_HOUR: twelve_q <= cfg_wdata_i[0];
        CFG_ZONE_OFFSET: zone_q   <= $signed(cfg_wdata_i);
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads, so bubbles collapse and stalls lose nothing.
  // ---------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: field decode and calendar range check
  // ---------------------------------------------------------------
  logic [7:0] sec_dec, min_dec, day_dec, mon_dec, year_dec;
  logic [7:0] hr_byte, hr_bin, hr_dec;
  logic       pm;
  logic       bad1_d;

  always_comb begin
    sec_dec  = bcd_q ? bcd_to_bin(s_axis_tdata[7:0])   : s_axis_tdata[7:0];
    min_dec  = bcd_q ? bcd_to_bin(s_axis_tdata[15:8])  : s_axis_tdata[15:8];
    day_dec  = bcd_q ? bcd_to_bin(s_axis_tdata[31:24]) : s_axis_tdata[31:24];
    mon_dec  = bcd_q ? bcd_to_bin(s_axis_tdata[39:32]) : s_axis_tdata[39:32];
    year_dec = bcd_q ? bcd_to_bin(s_axis_tdata[47:40]) : s_axis_tdata[47:40];

    // 12-hour: strip PM flag, 12 -> 0, PM adds 12
    pm      = twelve_q && ((s_axis_tdata[23:16] & PM_FLAG) != 8'd0);
    hr_byte = twelve_q ? (s_axis_tdata[23:16] & ~PM_FLAG) : s_axis_tdata[23:16];
    hr_bin  = bcd_q ? bcd_to_bin(hr_byte) : hr_byte;
    hr_dec  = (twelve_q && (hr_bin == 8'd12)) ? 8'd0 : hr_bin;
    if (pm) hr_dec = hr_dec + 8'd12;

    bad1_d = (sec_dec > 8'd59) || (min_dec > 8'd59) || (hr_dec > 8'd23) ||
             (day_dec < 8'd1) || (day_dec > 8'd31) ||
             (mon_dec < 8'd1) || (mon_dec > 8'd12) || (year_dec > 8'd99);
  end

  logic [5:0] sec1_q, min1_q;
  logic [4:0] hour1_q, day1_q;
  logic [3:0] mon1_q;
  logic [6:0] year1_q;
  logic       bad1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sec1_q  <= sec_dec[5:0];
      min1_q  <= min_dec[5:0];
      hour1_q <= hr_dec[4:0];
      day1_q  <= day_dec[4:0];
      mon1_q  <= mon_dec[3:0];
      year1_q <= year_dec[6:0];
      bad1_q  <= bad1_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: day number since 1970 and zone-adjusted time of day
  // ---------------------------------------------------------------
  logic [7:0]         ey;
  logic               leap;
  logic [15:0]        days2_d;
  logic [16:0]        tod_u;
  logic signed [18:0] tod2_d;

  always_comb begin
    ey      = {1'b0, year1_q} + EPOCH_YEARS;
    leap    = (year1_q[1:0] == 2'b00);
    days2_d = 16'(17'(ey) * DAYS_PER_YR + 17'((ey + 8'd1) >> 2) +
                  17'(cum_days(mon1_q, leap)) + 17'(day1_q) - 17'd1);
    tod_u   = 17'(17'(hour1_q) * SEC_PER_HR + 17'(min1_q) * SEC_PER_MIN + 17'(sec1_q));
    tod2_d  = $signed({2'b00, tod_u}) + 19'(zone_q);
  end

  logic [15:0]        days2_q;
  logic signed [18:0] tod2_q;
  logic               bad2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      days2_q <= days2_d;
      tod2_q  <= tod2_d;
      bad2_q  <= bad1_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: days * 86400 (16 x 17 bit product fits in 32 bits)
  // ---------------------------------------------------------------
  logic [31:0]        prod3_q;
  logic signed [18:0] tod3_q;
  logic               bad3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      prod3_q <= 32'(days2_q) * SEC_PER_DAY;
      tod3_q  <= tod2_q;
      bad3_q  <= bad2_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: final sum, modulo 2^32; zero on a bad date
  // ---------------------------------------------------------------
  logic [31:0] epoch4_q;
  logic        err4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      epoch4_q <= bad3_q ? 32'd0 : (prod3_q + 32'(tod3_q));
      err4_q   <= bad3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = epoch4_q;
  assign m_axis_tuser  = err4_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `ASSERT_CLK(a_err_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0, "error result not zero")
  `ASSERT_CLK(a_s1_range, v1_q && !bad1_q |-> (mon1_q != 4'd0) && (mon1_q <= 4'd12) && (day1_q != 5'd0) && (hour1_q <= 5'd23), "stage 1 passed an out-of-range date")
  `ASSERT_CLK(a_hold_out, v4_q && !m_axis_tready |=> v4_q, "stalled result dropped")
  `ASSERT_NEVER(a_full_only, !s_axis_tready && !(v1_q && v2_q && v3_q && v4_q), "input stalled with a bubble in the pipeline")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for rtc_bcd_date_to_epoch: RTC snapshots in, epoch seconds out.
// Depends on rtcb2e_pkg (register indexes, widths, PM flag) and the converter RTL.
// Predicts each result, checks in order, sweeps register settings and handshake stalls.

module tb_top;
  import rtcb2e_pkg::*;

  localparam int NUM_PHASES     = 8;
  localparam int RAND_PER_PHASE = 175;
  localparam int DRAIN_CYCLES   = 8;     // pipeline is 4 deep, leave some margin
  localparam int HOLD_CYCLES    = 60;    // long output stall to back up the pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with work pending but no handshake

  typedef struct packed {
    logic [31:0] secs;
    logic        err;
  } epoch_exp_t;

  // days before the first of each month, non-leap year
  int unsigned month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // per-phase register settings and handshake pressure
  bit ph_bcd[NUM_PHASES]       = '{1, 0, 1, 0, 1, 0, 1, 1};
  bit ph_twelve[NUM_PHASES]    = '{0, 0, 1, 1, 0, 0, 1, 0};
  int ph_zone[NUM_PHASES]      = '{0, 100800, -100800, 131071, -131072, 0, 0, 0};
  int ph_snd_idle[NUM_PHASES]  = '{0, 67, 0, 34, 0, 67, 0, 34};
  int ph_rcv_stall[NUM_PHASES] = '{0, 0, 67, 34, 0, 0, 67, 34};

  // DUT connections; the ones driven here are all known from time zero
  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [ZoneW-1:0]   cfg_wdata = '0;
  logic               s_valid   = 1'b0;
  logic               s_ready;
  logic [47:0]        s_data    = '0;
  logic               m_valid;
  logic               m_ready   = 1'b0;
  logic [31:0]        m_data;
  logic               m_user;

  // stimulus and scoreboard state
  logic [47:0] snap_q[$];        // snapshots waiting for the driver
  epoch_exp_t  epoch_exp_q[$];   // predicted results, oldest first
  epoch_exp_t  want;

  // register shadows, reset values of the block
  bit                     bcd_sh    = 1'b1;
  bit                     twelve_sh = 1'b0;
  logic signed [ZoneW-1:0] zone_sh  = '0;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_arm      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  int n_in       = 0;
  int n_checked  = 0;
  int n_bad_date = 0;
  int n_backpr   = 0;
  int n_fail     = 0;

  rtc_bcd_date_to_epoch u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned dec_byte(input logic [7:0] b, input bit bcd);
    // BCD nibbles above 9 are not rejected here; only the range check can reject the result
    return bcd ? int'(b[7:4]) * 10 + int'(b[3:0]) : int'(b);
  endfunction

  function automatic logic [7:0] enc_byte(input int unsigned v, input bit bcd);
    return bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
  endfunction

  // field order in tdata, lowest byte first: sec, min, hour, day, month, year
  function automatic logic [47:0] pack_snap(input logic [7:0] sec, mi, hr, dy, mo, yr);
    return {yr, mo, dy, hr, mi, sec};
  endfunction

  // Expected conversion of one snapshot under the given register values.
  function automatic epoch_exp_t predict_epoch(input logic [47:0] snap, input bit bcd,
                                               input bit twelve,
                                               input logic signed [ZoneW-1:0] zone);
    epoch_exp_t  r;
    int unsigned sec, mi, hr, dy, mo, yr, ey;
    logic [7:0]  hb;
    bit          pm;
    longint      days, total;
    sec = dec_byte(snap[7:0], bcd);
    mi  = dec_byte(snap[15:8], bcd);
    dy  = dec_byte(snap[31:24], bcd);
    mo  = dec_byte(snap[39:32], bcd);
    yr  = dec_byte(snap[47:40], bcd);
    // 12-hour: top bit is PM, 12 wraps to 0 before PM adds 12
    hb = snap[23:16];
    pm = 1'b0;
    if (twelve) begin
      pm    = hb[7];
      hb[7] = 1'b0;
    end
    hr = dec_byte(hb, bcd);
    if (twelve && hr == 12) hr = 0;
    if (pm) hr += 12;
    // day is only checked against 1..31, not the month length
    r.err = (sec > 59) || (mi > 59) || (hr > 23) || (dy < 1) || (dy > 31) ||
            (mo < 1) || (mo > 12) || (yr > 99);
    if (r.err) begin
      r.secs = '0;
    end else begin
      ey    = yr + 30;
      days  = longint'(ey * 365 + (ey + 1) / 4 + month_start[mo - 1] + dy - 1);
      if ((yr % 4) == 0 && mo > 2) days += 1;
      total = days * 86400 + longint'(hr * 3600 + mi * 60 + sec) + longint'(zone);
      r.secs = total[31:0];
    end
    return r;
  endfunction

  // One register write; block must be idle when this is called.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ZoneW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued snapshots, idling at the phase's rate
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else if (!s_valid || s_ready) begin
      // current item (if any) taken at this edge, so a new one may go up
      if (snap_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s_valid <= 1'b1;
        s_data  <= snap_q.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when armed
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: register shadows, prediction at input accept, in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BCD_MODE:    bcd_sh    = cfg_wdata[0];
          CFG_TWELVE_HOUR: twelve_sh = cfg_wdata[0];
          CFG_ZONE_OFFSET: zone_sh   = cfg_wdata;
          default: ;
        endcase
      end

      if (s_valid && !s_ready) n_backpr++;

      if (s_valid && s_ready) begin
        epoch_exp_q.push_back(predict_epoch(s_data, bcd_sh, twelve_sh, zone_sh));
        n_in++;
      end

      if (m_valid && m_ready) begin
        if (epoch_exp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got epoch %0d error %0b",
                   $time, m_data, m_user);
          n_fail++;
        end else begin
          want = epoch_exp_q.pop_front();
          if (m_data !== want.secs) begin
            $display("%0t: epoch_seconds mismatch: expected %0d, got %0d",
                     $time, want.secs, m_data);
            n_fail++;
          end
          if (m_user !== want.err) begin
            $display("%0t: date_error mismatch: expected %0b, got %0b",
                     $time, want.err, m_user);
            n_fail++;
          end
          n_checked++;
          if (want.err) n_bad_date++;
        end
      end

      // watchdog count: only while work is outstanding and nothing moves
      if ((s_valid && s_ready) || (m_valid && m_ready) ||
          (snap_q.size() == 0 && !s_valid && epoch_exp_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, then one phase per register setting
  // ---------------------------------------------------------------------------
  initial begin
    int          ph, n, r, zone_val;
    int unsigned sec, mi, hr, dy, mo, yr, h12;
    logic [7:0]  hb;
    logic [47:0] snap;
    bit          bcd, twelve;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      bcd      = ph_bcd[ph];
      twelve   = ph_twelve[ph];
      zone_val = ph_zone[ph];
      if (ph == 5 || ph == 6) zone_val = int'($urandom_range(201600)) - 100800;

      write_reg(CFG_BCD_MODE, ZoneW'(bcd));
      write_reg(CFG_TWELVE_HOUR, ZoneW'(twelve));
      write_reg(CFG_ZONE_OFFSET, ZoneW'(zone_val));
      snd_idle_pct  <= ph_snd_idle[ph];
      rcv_stall_pct <= ph_rcv_stall[ph];

      if (ph == 0) begin
        // BCD, 24-hour, no offset: calendar ends, leap handling, range edges
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
        snap_q.push_back(pack_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
        snap_q.push_back(pack_snap(8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h23));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24));
        snap_q.push_back(pack_snap(8'h10, 8'h20, 8'h08, 8'h31, 8'h02, 8'h23)); // Feb 31 passes
        snap_q.push_back(pack_snap(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h5A, 8'h00, 8'h01, 8'h01, 8'h00)); // nibble >9 -> 60
        snap_q.push_back(pack_snap(8'h1F, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00)); // nibble >9 -> 25
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9A)); // year 100
        snap_q.push_back(pack_snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      end else if (ph == 2) begin
        // 12-hour BCD: midnight, noon, PM add, PM overflow, hour 0 and 13 without PM
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h12, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h92, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h81, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h59, 8'h59, 8'h91, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h99, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h00, 8'h15, 8'h06, 8'h10));
        snap_q.push_back(pack_snap(8'h00, 8'h00, 8'h13, 8'h15, 8'h06, 8'h10));
      end

      // Random part: mostly valid dates coded for the current mode, some
      // with one corrupted byte, some fully random bytes.
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        sec = $urandom_range(59);
        mi  = $urandom_range(59);
        hr  = $urandom_range(23);
        dy  = $urandom_range(31, 1);
        mo  = $urandom_range(12, 1);
        yr  = $urandom_range(99);
        if (twelve) begin
          h12 = hr % 12;
          if (h12 == 0) h12 = 12;
          hb = enc_byte(h12, bcd) | ((hr >= 12) ? PM_FLAG : 8'h00);
        end else begin
          hb = enc_byte(hr, bcd);
        end
        snap = pack_snap(enc_byte(sec, bcd), enc_byte(mi, bcd), hb,
                         enc_byte(dy, bcd), enc_byte(mo, bcd), enc_byte(yr, bcd));
        r = $urandom_range(99);
        if (r < 10)
          snap = 48'({$urandom, $urandom});
        else if (r < 25)
          snap[8 * $urandom_range(5) +: 8] = 8'($urandom_range(255));
        snap_q.push_back(snap);
      end

      // long receiver hold-off while the sender keeps offering: fills the pipe
      if (ph == 4) begin
        @(posedge clk);
        hold_arm <= hold_arm + 1;
      end

      // let everything drain before touching registers again
      while (snap_q.size() != 0 || s_valid || epoch_exp_q.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    $display("Ran %0d snapshots over %0d register settings (BCD/binary, 12/24 h, zone ends);",
             n_in, NUM_PHASES);
    $display("%0d results checked, %0d bad dates, input stalled %0d cycles, %0d mismatches.",
             n_checked, n_bad_date, n_backpr, n_fail);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
